// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// clocked assertion shorthands used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// File: design/bmf_pkg.sv
// ----------------------------------------------------------------------------
// bmf_pkg
// shared widths, register indexes and constants of the box mean filter
// ----------------------------------------------------------------------------
package bmf_pkg;

    localparam int PIX_W     = 8;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 11'd512;
    localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 11'd512;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    // 2x2 and 3x3 sums
    localparam int SUM2_W = PIX_W + 2;
    localparam int SUM3_W = PIX_W + 4;

    // floor(s / 9) = (s * DIV9_MUL) >> DIV9_SHIFT for s below 2**SUM3_W
    localparam int               DIV9_SHIFT = 16;
    localparam int               DIV9_MUL_W = 13;
    localparam logic [DIV9_MUL_W-1:0] DIV9_MUL = 13'd7282;

    // per-item control carried from acceptance to the result
    typedef struct packed {
        logic in_region;
        logic frame_last;
    } bmf_tag_t;

endpackage

// File: design/bmf_line_mem.sv
// ----------------------------------------------------------------------------
// bmf_line_mem
// line store: one write port, one registered read port, write-to-read forwarding
// ----------------------------------------------------------------------------
module bmf_line_mem #(
    parameter int DEPTH = 1024,
    parameter int DW    = 16
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DW-1:0]            rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DW-1:0]            wr_data
);

    logic [DW-1:0] line_mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            line_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            // same entry written this cycle: take the new data
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= line_mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/bmf_mean.sv
// ----------------------------------------------------------------------------
// bmf_mean
// window columns, 2x2 and 3x3 sums, divide and result register
// ----------------------------------------------------------------------------
module bmf_mean
    import bmf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  logic [PIX_W-1:0] pixel,
    input  logic [PIX_W-1:0] up,
    input  logic [PIX_W-1:0] up2,
    input  bmf_tag_t         tag,
    output logic [PIX_W-1:0] mean_small,
    output logic [PIX_W-1:0] mean_large,
    output logic             interior,
    output logic             frame_end
);

    localparam int PROD_W = SUM3_W + DIV9_MUL_W;

    // index 0 is row-2, 1 is row-1, 2 is the current row
    logic [PIX_W-1:0] win0_reg [3];
    logic [PIX_W-1:0] win1_reg [3];

    logic [PIX_W-1:0] mean_small_reg;
    logic [PIX_W-1:0] mean_large_reg;
    logic             interior_reg;
    logic             frame_end_reg;

    logic [SUM2_W-1:0] sum2;
    logic [SUM3_W-1:0] sum3;
    logic [PROD_W-1:0] prod9;
    logic [PIX_W-1:0]  m2;
    logic [PIX_W-1:0]  m3;

    always_comb
    begin
        sum2 = SUM2_W'(pixel) + SUM2_W'(up) + SUM2_W'(win0_reg[1]) + SUM2_W'(win0_reg[2]);
        sum3 = SUM3_W'(sum2) + SUM3_W'(up2) + SUM3_W'(win0_reg[0])
             + SUM3_W'(win1_reg[0]) + SUM3_W'(win1_reg[1]) + SUM3_W'(win1_reg[2]);
        prod9 = PROD_W'(sum3) * PROD_W'(DIV9_MUL);
        m2    = sum2[SUM2_W-1:2];
        m3    = prod9[DIV9_SHIFT +: PIX_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win0_reg[i] <= '0;
                win1_reg[i] <= '0;
            end
        end
        else if (load)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win1_reg[i] <= win0_reg[i];
            end
            win0_reg[0] <= up2;
            win0_reg[1] <= up;
            win0_reg[2] <= pixel;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            mean_small_reg <= tag.in_region ? m2 : pixel;
            mean_large_reg <= tag.in_region ? m3 : pixel;
            interior_reg   <= tag.in_region;
            frame_end_reg  <= tag.frame_last;
        end
    end

    assign mean_small = mean_small_reg;
    assign mean_large = mean_large_reg;
    assign interior   = interior_reg;
    assign frame_end  = frame_end_reg;

endmodule

// File: design/box_mean_filter_2x2_3x3.sv
// ----------------------------------------------------------------------------
// box_mean_filter_2x2_3x3
// causal 2x2 and 3x3 box mean filter on an 8-bit raster pixel stream
// ----------------------------------------------------------------------------
// Takes one pixel per clock while the output side is ready and gives one
// result per pixel, through the stage-one register and the result register. The
// two previous rows sit in one MAX_WIDTH x 16 line memory: the entry for the
// column is read when the pixel is accepted and written back as the pixel
// moves on to the result register, with forwarding for back-to-back access to
// the same column, so the sustained rate is one pixel per cycle. The input
// stalls only while a result waits on the output and a second pixel is
// already held. No clearing pass runs after reset. Frame width and height are
// to be written through the configuration port only while the block is idle;
// the block does not enforce this. They take values from 1 to MAX_WIDTH /
// MAX_HEIGHT (0 counts as 1, larger values saturate).
// ----------------------------------------------------------------------------
module box_mean_filter_2x2_3x3
    import bmf_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [PIX_W-1:0]     pixel,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [PIX_W-1:0]     mean_small,
    output logic [PIX_W-1:0]     mean_large,
    output logic                 interior,
    output logic                 frame_end
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int WCMPW = (WW > CFG_W) ? WW : CFG_W;
    localparam int HCMPW = (HW > CFG_W) ? HW : CFG_W;
    localparam int LDW   = 2 * PIX_W;

    logic [CFG_W-1:0] frame_width_reg;
    logic [CFG_W-1:0] frame_height_reg;
    logic [CW-1:0]    col_reg;
    logic [RW-1:0]    row_reg;
    logic             s1_valid_reg;
    logic [PIX_W-1:0] s1_px_reg;
    logic [CW-1:0]    s1_col_reg;
    bmf_tag_t         s1_tag_reg;
    logic             out_valid_reg;

    logic [WW-1:0]    eff_w;
    logic [HW-1:0]    eff_h;
    logic [WW:0]      col_p1;
    logic [WW:0]      col_p3;
    logic [HW:0]      row_p1;
    logic [HW:0]      row_p3;
    logic             row_end;
    bmf_tag_t         tag_next;
    logic [CW-1:0]    col_next;
    logic [RW-1:0]    row_next;

    logic             accept;
    logic             advance;
    logic [LDW-1:0]   ld_rd;
    logic [PIX_W-1:0] up;
    logic [PIX_W-1:0] up2;

    // effective frame size
    always_comb
    begin
        if (frame_width_reg == '0)
        begin
            eff_w = WW'(1);
        end
        else if (WCMPW'(frame_width_reg) > WCMPW'(MAX_WIDTH))
        begin
            eff_w = WW'(MAX_WIDTH);
        end
        else
        begin
            eff_w = WW'(frame_width_reg);
        end

        if (frame_height_reg == '0)
        begin
            eff_h = HW'(1);
        end
        else if (HCMPW'(frame_height_reg) > HCMPW'(MAX_HEIGHT))
        begin
            eff_h = HW'(MAX_HEIGHT);
        end
        else
        begin
            eff_h = HW'(frame_height_reg);
        end
    end

    // position of the accepted pixel
    always_comb
    begin
        col_p1  = (WW + 1)'(col_reg) + (WW + 1)'(1);
        col_p3  = (WW + 1)'(col_reg) + (WW + 1)'(3);
        row_p1  = (HW + 1)'(row_reg) + (HW + 1)'(1);
        row_p3  = (HW + 1)'(row_reg) + (HW + 1)'(3);
        row_end = col_p1 >= (WW + 1)'(eff_w);

        tag_next.in_region  = (row_reg >= RW'(2)) && (row_p3 <= (HW + 1)'(eff_h))
                           && (col_reg >= CW'(2)) && (col_p3 <= (WW + 1)'(eff_w));
        tag_next.frame_last = row_end && (row_p1 >= (HW + 1)'(eff_h));

        if (row_end)
        begin
            col_next = '0;
            row_next = tag_next.frame_last ? '0 : row_reg + RW'(1);
        end
        else
        begin
            col_next = col_reg + CW'(1);
            row_next = row_reg;
        end
    end

    assign advance   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || advance;
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= RST_FRAME_WIDTH;
            frame_height_reg <= RST_FRAME_HEIGHT;
            col_reg          <= '0;
            row_reg          <= '0;
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                    REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                    default:          ;
                endcase
            end
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_px_reg  <= pixel;
            s1_col_reg <= col_reg;
            s1_tag_reg <= tag_next;
        end
    end

    // entry layout: upper byte two rows up, lower byte one row up
    assign up  = ld_rd[PIX_W-1:0];
    assign up2 = ld_rd[LDW-1:PIX_W];

    bmf_line_mem #(
        .DEPTH (MAX_WIDTH),
        .DW    (LDW)
    ) u_line_mem (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (ld_rd),
        .wr_en   (advance),
        .wr_addr (s1_col_reg),
        .wr_data ({up, s1_px_reg})
    );

    bmf_mean u_mean (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance),
        .pixel      (s1_px_reg),
        .up         (up),
        .up2        (up2),
        .tag        (s1_tag_reg),
        .mean_small (mean_small),
        .mean_large (mean_large),
        .interior   (interior),
        .frame_end  (frame_end)
    );

endmodule

// File: design/bmf_checker.sv
// ----------------------------------------------------------------------------
// bmf_checker
// port-level checks of the box mean filter, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bmf_checker
    import bmf_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input logic [PIX_W-1:0] mean_small,
    input logic [PIX_W-1:0] mean_large,
    input logic             interior
);

    // stalled result holds
    `ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(mean_small) && $stable(mean_large), "stalled result changed")

    // input stalls only behind a waiting result
    `ASSERT_NEVER(a_no_idle_stall, clk, rst_n, !in_ready && !out_valid, "input stalled with empty output")

    // a new result follows an accepted pixel request
    `ASSERT_CLK(a_rise_after_req, clk, rst_n, $rose(out_valid) |-> $past(in_valid && in_ready, 2), "result without pixel request")

    // border pixels pass unchanged to both means
    `ASSERT_CLK(a_border_pass, clk, rst_n, out_valid && !interior |-> mean_small == mean_large, "border means differ")

endmodule

bind box_mean_filter_2x2_3x3 bmf_checker u_bmf_checker (.*);
